FILE: rtl/tds_pkg.sv
// Shared types and constants for the triangle depth sorter.
package tds_pkg;

  localparam int MAX_TRIANGLES_DEF = 64;
  localparam int IDX_W             = 16;
  localparam int DEPTH_W           = 32;
  localparam int KEY_W             = 34;

  // One stored triangle: sort key and the three vertex indices.
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [IDX_W-1:0]        idx_a;
    logic [IDX_W-1:0]        idx_b;
    logic [IDX_W-1:0]        idx_c;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT_INIT,
    ST_PASS_CHK,
    ST_RUN_CHK,
    ST_FETCH,
    ST_MERGE,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic sort_init;
    logic pass_init;
    logic pass_end;
    logic run_init;
    logic run_end;
    logic step;
    logic emit_init;
    logic emit_rd;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sort_done;
    logic pass_done;
    logic run_done;
    logic emit_last;
  } dp_status_t;

endpackage

FILE: rtl/tds_ctrl.sv
// Sequencing state machine: load, merge passes, emit.
module tds_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                last_in,
  input  tds_pkg::dp_status_t status,
  output tds_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);
  import tds_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && last_in) state_nxt = ST_SORT_INIT;
      end
      ST_SORT_INIT: state_nxt = ST_PASS_CHK;
      ST_PASS_CHK: begin
        state_nxt = status.sort_done ? ST_EMIT : ST_RUN_CHK;
      end
      ST_RUN_CHK: begin
        state_nxt = status.pass_done ? ST_PASS_CHK : ST_FETCH;
      end
      ST_FETCH: begin
        state_nxt = status.run_done ? ST_RUN_CHK : ST_MERGE;
      end
      ST_MERGE: state_nxt = ST_FETCH;
      ST_EMIT: begin
        if (status.emit_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE:      cmd.load = start;
      ST_SORT_INIT: cmd.sort_init = 1'b1;
      ST_PASS_CHK: begin
        if (status.sort_done) cmd.emit_init = 1'b1;
        else                  cmd.pass_init = 1'b1;
      end
      ST_RUN_CHK: begin
        if (status.pass_done) cmd.pass_end = 1'b1;
        else                  cmd.run_init = 1'b1;
      end
      ST_FETCH: begin
        if (status.run_done) cmd.run_end = 1'b1;
      end
      ST_MERGE:     cmd.step = 1'b1;
      ST_EMIT:      cmd.emit_rd = 1'b1;
      default:      cmd = '0;
    endcase
  end

endmodule

FILE: rtl/tds_datapath.sv
// Ping-pong triangle stores, merge unit, counters and result registers.
module tds_datapath #(
  parameter int MAX_TRIANGLES = tds_pkg::MAX_TRIANGLES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tds_pkg::ctrl_cmd_t                     cmd,
  output tds_pkg::dp_status_t                    status,
  input  logic [tds_pkg::IDX_W-1:0]              in_vertex_index_a,
  input  logic [tds_pkg::IDX_W-1:0]              in_vertex_index_b,
  input  logic [tds_pkg::IDX_W-1:0]              in_vertex_index_c,
  input  logic signed [tds_pkg::DEPTH_W-1:0]     in_depth_a,
  input  logic signed [tds_pkg::DEPTH_W-1:0]     in_depth_b,
  input  logic signed [tds_pkg::DEPTH_W-1:0]     in_depth_c,
  output logic                                   out_valid,
  output logic [tds_pkg::IDX_W-1:0]              out_index_a,
  output logic [tds_pkg::IDX_W-1:0]              out_index_b,
  output logic [tds_pkg::IDX_W-1:0]              out_index_c,
  output logic signed [tds_pkg::KEY_W-1:0]       out_depth_sum,
  output logic                                   out_last_out
);
  import tds_pkg::*;

  localparam int AW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
  localparam int FW = $clog2(MAX_TRIANGLES + 1);
  localparam int CW = AW + 2;

  entry_t mem0 [MAX_TRIANGLES];
  entry_t mem1 [MAX_TRIANGLES];

  entry_t rd0a_r, rd0b_r, rd1a_r, rd1b_r;
  entry_t src_a, src_b, chosen, load_entry;
  entry_t wd0, wd1;

  logic [FW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] width_r, width_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [FW-1:0] mid_r, mid_nxt, hi_r, hi_nxt;
  logic [FW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic          src_r, src_nxt;
  logic          out_valid_r, out_last_r;

  logic [CW-1:0] n_ext, mid_sum, hi_sum;
  logic [AW-1:0] ra, rb, wa0, wa1;
  logic          we0, we1, take_i, has_room;
  logic signed [KEY_W-1:0] key_sum;

  assign n_ext    = CW'(fill_r);
  assign mid_sum  = lo_r + width_r;
  assign hi_sum   = lo_r + (width_r << 1);
  assign has_room = (fill_r < FW'(MAX_TRIANGLES));

  // Exact three-term sum; 34 bits cannot overflow.
  assign key_sum = {{(KEY_W-DEPTH_W){in_depth_a[DEPTH_W-1]}}, in_depth_a}
                 + {{(KEY_W-DEPTH_W){in_depth_b[DEPTH_W-1]}}, in_depth_b}
                 + {{(KEY_W-DEPTH_W){in_depth_c[DEPTH_W-1]}}, in_depth_c};

  always_comb begin
    load_entry.key   = key_sum;
    load_entry.idx_a = in_vertex_index_a;
    load_entry.idx_b = in_vertex_index_b;
    load_entry.idx_c = in_vertex_index_c;
  end

  assign src_a  = src_r ? rd1a_r : rd0a_r;
  assign src_b  = src_r ? rd1b_r : rd0b_r;
  // Left run wins ties to keep load order.
  assign take_i = (i_r < mid_r) && ((j_r >= hi_r) || (src_a.key <= src_b.key));
  assign chosen = take_i ? src_a : src_b;

  assign ra = cmd.emit_rd ? k_r[AW-1:0] : i_r[AW-1:0];
  assign rb = j_r[AW-1:0];

  always_comb begin
    we0 = 1'b0;
    we1 = 1'b0;
    wa0 = fill_r[AW-1:0];
    wa1 = k_r[AW-1:0];
    wd0 = load_entry;
    wd1 = chosen;
    if (cmd.load && has_room) begin
      we0 = 1'b1;
    end else if (cmd.step) begin
      if (src_r) begin
        we0 = 1'b1;
        wa0 = k_r[AW-1:0];
        wd0 = chosen;
      end else begin
        we1 = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we0) mem0[wa0] <= wd0;
    rd0a_r <= mem0[ra];
    rd0b_r <= mem0[rb];
  end

  always_ff @(posedge clk) begin
    if (we1) mem1[wa1] <= wd1;
    rd1a_r <= mem1[ra];
    rd1b_r <= mem1[rb];
  end

  always_comb begin
    fill_nxt  = fill_r;
    width_nxt = width_r;
    lo_nxt    = lo_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    src_nxt   = src_r;
    if (cmd.load && has_room) fill_nxt = fill_r + FW'(1);
    if (cmd.sort_init) begin
      width_nxt = CW'(1);
      src_nxt   = 1'b0;
    end
    if (cmd.pass_init) lo_nxt = '0;
    if (cmd.pass_end) begin
      width_nxt = width_r << 1;
      src_nxt   = ~src_r;
    end
    if (cmd.run_init) begin
      mid_nxt = (mid_sum >= n_ext) ? fill_r : mid_sum[FW-1:0];
      hi_nxt  = (hi_sum >= n_ext) ? fill_r : hi_sum[FW-1:0];
      i_nxt   = lo_r[FW-1:0];
      j_nxt   = (mid_sum >= n_ext) ? fill_r : mid_sum[FW-1:0];
      k_nxt   = lo_r[FW-1:0];
    end
    if (cmd.run_end) lo_nxt = hi_sum;
    if (cmd.step) begin
      k_nxt = k_r + FW'(1);
      if (take_i) i_nxt = i_r + FW'(1);
      else        j_nxt = j_r + FW'(1);
    end
    if (cmd.emit_init) k_nxt = '0;
    if (cmd.emit_rd) begin
      k_nxt = k_r + FW'(1);
      if (status.emit_last) fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= cmd.emit_rd;
      out_last_r  <= cmd.emit_rd && status.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    width_r <= width_nxt;
    lo_r    <= lo_nxt;
    mid_r   <= mid_nxt;
    hi_r    <= hi_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    src_r   <= src_nxt;
  end

  always_comb begin
    status.sort_done = (width_r >= n_ext);
    status.pass_done = (lo_r >= n_ext);
    status.run_done  = (i_r == mid_r) && (j_r == hi_r);
    status.emit_last = ((k_r + FW'(1)) == fill_r);
  end

  assign out_valid     = out_valid_r;
  assign out_last_out  = out_last_r;
  assign out_index_a   = src_a.idx_a;
  assign out_index_b   = src_a.idx_b;
  assign out_index_c   = src_a.idx_c;
  assign out_depth_sum = src_a.key;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(MAX_TRIANGLES))
    else $error("fill count beyond store depth");

  a_step_live: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !status.run_done)
    else $error("merge step on an exhausted run");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_r |-> out_valid_r)
    else $error("last marker without strobe");

  a_empty_after: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_rd && status.emit_last) |=> (fill_r == '0))
    else $error("set not emptied after final transfer");
`endif

endmodule

FILE: rtl/triangle_depth_sorter.sv
// Top level of the painter's-order triangle depth sorter.
//
// Load triangles with start while busy is low, one transfer per cycle; each
// stores its three vertex indices and the exact 34-bit sum of its Q16.16
// depths. Triangles beyond MAX_TRIANGLES are dropped. The transfer with
// in_last_in high raises busy, stable-merge-sorts the set by ascending sum
// (ties keep load order) and then presents the triangles on the out_ ports,
// one per cycle, each for a single cycle marked by out_valid, the final one
// with out_last_out. The receiver cannot stall: take every transfer as it
// comes. For n stored triangles the sort runs ceil(log2 n) passes, doubling
// the run width after each pass, in the single merge unit whose store reads
// are registered (read in ST_FETCH, compare and write in ST_MERGE);
// ST_SORT_INIT sets up the sort and a final ST_PASS_CHK ends it. Emission
// then reads the sorted store in order through the registered read port.
// Busy drops in the cycle of the last strobe, so a new set may begin loading
// then.
module triangle_depth_sorter #(
  parameter int MAX_TRIANGLES = tds_pkg::MAX_TRIANGLES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [tds_pkg::IDX_W-1:0]          in_vertex_index_a,
  input  logic [tds_pkg::IDX_W-1:0]          in_vertex_index_b,
  input  logic [tds_pkg::IDX_W-1:0]          in_vertex_index_c,
  input  logic signed [tds_pkg::DEPTH_W-1:0] in_depth_a,
  input  logic signed [tds_pkg::DEPTH_W-1:0] in_depth_b,
  input  logic signed [tds_pkg::DEPTH_W-1:0] in_depth_c,
  input  logic                               in_last_in,
  output logic                               out_valid,
  output logic [tds_pkg::IDX_W-1:0]          out_index_a,
  output logic [tds_pkg::IDX_W-1:0]          out_index_b,
  output logic [tds_pkg::IDX_W-1:0]          out_index_c,
  output logic signed [tds_pkg::KEY_W-1:0]   out_depth_sum,
  output logic                               out_last_out
);
  import tds_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequence load, merge passes and emission.
  tds_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .last_in (in_last_in),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Hold the stores, merge unit and result registers.
  tds_datapath #(
    .MAX_TRIANGLES (MAX_TRIANGLES)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .in_vertex_index_a (in_vertex_index_a),
    .in_vertex_index_b (in_vertex_index_b),
    .in_vertex_index_c (in_vertex_index_c),
    .in_depth_a        (in_depth_a),
    .in_depth_b        (in_depth_b),
    .in_depth_c        (in_depth_c),
    .out_valid         (out_valid),
    .out_index_a       (out_index_a),
    .out_index_b       (out_index_b),
    .out_index_c       (out_index_c),
    .out_depth_sum     (out_depth_sum),
    .out_last_out      (out_last_out)
  );

endmodule

FILE: test/tds_checker.sv
// Checker for the triangle depth sorter: watches both channels, predicts the sorted frame, compares.
`timescale 1ns / 100ps

module tds_checker #(
  parameter int MAX_TRIANGLES = tds_pkg::MAX_TRIANGLES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic [tds_pkg::IDX_W-1:0]          in_vertex_index_a,
  input  logic [tds_pkg::IDX_W-1:0]          in_vertex_index_b,
  input  logic [tds_pkg::IDX_W-1:0]          in_vertex_index_c,
  input  logic signed [tds_pkg::DEPTH_W-1:0] in_depth_a,
  input  logic signed [tds_pkg::DEPTH_W-1:0] in_depth_b,
  input  logic signed [tds_pkg::DEPTH_W-1:0] in_depth_c,
  input  logic                               in_last_in,
  input  logic                               out_valid,
  input  logic [tds_pkg::IDX_W-1:0]          out_index_a,
  input  logic [tds_pkg::IDX_W-1:0]          out_index_b,
  input  logic [tds_pkg::IDX_W-1:0]          out_index_c,
  input  logic signed [tds_pkg::KEY_W-1:0]   out_depth_sum,
  input  logic                               out_last_out,
  output int                                 fail_count,
  output int                                 pending,
  output int                                 results_seen
);
  import tds_pkg::*;

  typedef struct {
    logic [IDX_W-1:0]        a;
    logic [IDX_W-1:0]        b;
    logic [IDX_W-1:0]        c;
    logic signed [KEY_W-1:0] sum;
    logic                    last;
  } tri_rec_t;

  tri_rec_t frame_q[$];     // triangles loaded into the current frame
  tri_rec_t painter_q[$];   // sorted triangles still to be emitted
  int       n_fail;
  int       n_seen;

  function automatic logic signed [KEY_W-1:0] depth_total(
    input logic signed [DEPTH_W-1:0] x,
    input logic signed [DEPTH_W-1:0] y,
    input logic signed [DEPTH_W-1:0] z
  );
    logic signed [KEY_W-1:0] sx, sy, sz;
    sx = x;
    sy = y;
    sz = z;
    return sx + sy + sz;
  endfunction

  // Stable insertion sort: an equal key lands behind those already placed.
  task automatic sort_frame();
    tri_rec_t ordered[$];
    tri_rec_t t;
    int       pos;
    ordered.delete();
    foreach (frame_q[i]) begin
      t   = frame_q[i];
      pos = ordered.size();
      while (pos > 0 && ordered[pos-1].sum > t.sum) pos--;
      ordered.insert(pos, t);
    end
    foreach (ordered[i]) begin
      t      = ordered[i];
      t.last = (i == ordered.size() - 1);
      painter_q.push_back(t);
    end
    frame_q.delete();
  endtask

  always @(posedge clk) begin
    tri_rec_t want;
    tri_rec_t got;
    if (!rst_n) begin
      frame_q.delete();
      painter_q.delete();
      n_fail = 0;
      n_seen = 0;
    end else begin
      if (out_valid) begin
        n_seen++;
        if (painter_q.size() == 0) begin
          $error("result transfer with nothing expected: idx %h %h %h sum %0d",
                 out_index_a, out_index_b, out_index_c, out_depth_sum);
          n_fail++;
        end else begin
          want = painter_q.pop_front();
          if (out_index_a !== want.a) begin
            $error("out_index_a: expected %h, actual %h", want.a, out_index_a);
            n_fail++;
          end
          if (out_index_b !== want.b) begin
            $error("out_index_b: expected %h, actual %h", want.b, out_index_b);
            n_fail++;
          end
          if (out_index_c !== want.c) begin
            $error("out_index_c: expected %h, actual %h", want.c, out_index_c);
            n_fail++;
          end
          if (out_depth_sum !== want.sum) begin
            $error("depth_sum: expected %0d, actual %0d", want.sum, out_depth_sum);
            n_fail++;
          end
          if (out_last_out !== want.last) begin
            $error("last_out: expected %b, actual %b", want.last, out_last_out);
            n_fail++;
          end
        end
      end
      if (start && !busy) begin
        if (frame_q.size() < MAX_TRIANGLES) begin
          got.a    = in_vertex_index_a;
          got.b    = in_vertex_index_b;
          got.c    = in_vertex_index_c;
          got.sum  = depth_total(in_depth_a, in_depth_b, in_depth_c);
          got.last = 1'b0;
          frame_q.push_back(got);
        end
        if (in_last_in) sort_frame();
      end
    end
    fail_count   <= n_fail;
    pending      <= painter_q.size();
    results_seen <= n_seen;
  end

endmodule

FILE: test/tb_top.sv
// Top of the triangle depth sorter testbench: clock, reset, frame stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import tds_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 6;
  localparam int STALL_LIMIT  = 20000;  // well beyond the quiet stretch of a full 64-triangle sort
  localparam int TAIL_CYCLES  = 16;
  localparam int RANDOM_ITEMS = 300;
  localparam int CALM_ITEMS   = 240;    // after this many random items, send back to back

  typedef enum int {
    DM_FULL,     // any 32-bit pattern
    DM_EXTREME,  // rails, zero and unit values
    DM_NEAR      // tiny spread, so keys collide and stability is exercised
  } depth_mode_t;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic [IDX_W-1:0]            in_vertex_index_a;
  logic [IDX_W-1:0]            in_vertex_index_b;
  logic [IDX_W-1:0]            in_vertex_index_c;
  logic signed [DEPTH_W-1:0]   in_depth_a;
  logic signed [DEPTH_W-1:0]   in_depth_b;
  logic signed [DEPTH_W-1:0]   in_depth_c;
  logic                        in_last_in;
  logic                        out_valid;
  logic [IDX_W-1:0]            out_index_a;
  logic [IDX_W-1:0]            out_index_b;
  logic [IDX_W-1:0]            out_index_c;
  logic signed [KEY_W-1:0]     out_depth_sum;
  logic                        out_last_out;

  int fail_count;
  int pending;
  int results_seen;
  int items_sent;
  int frames_sent;
  int quiet_cycles;

  triangle_depth_sorter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_vertex_index_a (in_vertex_index_a),
    .in_vertex_index_b (in_vertex_index_b),
    .in_vertex_index_c (in_vertex_index_c),
    .in_depth_a        (in_depth_a),
    .in_depth_b        (in_depth_b),
    .in_depth_c        (in_depth_c),
    .in_last_in        (in_last_in),
    .out_valid         (out_valid),
    .out_index_a       (out_index_a),
    .out_index_b       (out_index_b),
    .out_index_c       (out_index_c),
    .out_depth_sum     (out_depth_sum),
    .out_last_out      (out_last_out)
  );

  tds_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_vertex_index_a (in_vertex_index_a),
    .in_vertex_index_b (in_vertex_index_b),
    .in_vertex_index_c (in_vertex_index_c),
    .in_depth_a        (in_depth_a),
    .in_depth_b        (in_depth_b),
    .in_depth_c        (in_depth_c),
    .in_last_in        (in_last_in),
    .out_valid         (out_valid),
    .out_index_a       (out_index_a),
    .out_index_b       (out_index_b),
    .out_index_c       (out_index_c),
    .out_depth_sum     (out_depth_sum),
    .out_last_out      (out_last_out),
    .fail_count        (fail_count),
    .pending           (pending),
    .results_seen      (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Watchdog: count cycles in which neither channel makes a transfer, and give up
  // once the block has been silent far longer than the slowest sort could take.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one triangle and hold it until the block takes it. An optional gap of
  // idle cycles goes first; drop start only for the gap, never between two
  // back-to-back transfers, so start stays high across them.
  task automatic send_triangle(
    input logic [IDX_W-1:0]          ia,
    input logic [IDX_W-1:0]          ib,
    input logic [IDX_W-1:0]          ic,
    input logic signed [DEPTH_W-1:0] da,
    input logic signed [DEPTH_W-1:0] db,
    input logic signed [DEPTH_W-1:0] dc,
    input logic                      last,
    input int                        gap
  );
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_vertex_index_a = ia;
    in_vertex_index_b = ib;
    in_vertex_index_c = ic;
    in_depth_a        = da;
    in_depth_b        = db;
    in_depth_c        = dc;
    in_last_in        = last;
    start             = 1'b1;
    // busy read straight after the edge is the value the block used at that edge
    do @(posedge clk); while (busy);
    items_sent++;
    if (last) frames_sent++;
  endtask

  function automatic logic signed [DEPTH_W-1:0] pick_depth(input depth_mode_t mode);
    case (mode)
      DM_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return 32'sh7FFF_FFFF;
          1:       return 32'sh8000_0000;
          2:       return 32'sd0;
          3:       return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      DM_NEAR: return $urandom_range(0, 4) - 2;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int          directed_items;
    int          frame_no;
    int          frame_len;
    int          gap;
    bit          gappy;
    depth_mode_t frame_mode;
    depth_mode_t mode;

    rst_n             = 1'b0;
    start             = 1'b0;
    in_vertex_index_a = '0;
    in_vertex_index_b = '0;
    in_vertex_index_c = '0;
    in_depth_a        = '0;
    in_depth_b        = '0;
    in_depth_c        = '0;
    in_last_in        = 1'b0;
    items_sent        = 0;
    frames_sent       = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: the smallest frame, a single triangle marked last.
    send_triangle(16'h0000, 16'h0000, 16'h0000, 32'sd0, 32'sd0, 32'sd0, 1'b1, 0);

    // Directed: rails of every field, a negative sum and a run of equal keys
    // (sum 6) that must come out in load order, the last one on the final item.
    send_triangle(16'hFFFF, 16'hFFFF, 16'hFFFF,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 0);
    send_triangle(16'h0000, 16'h0000, 16'h0000,
                  32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 0);
    send_triangle(16'h0001, 16'h0002, 16'h0003, 32'sd1, 32'sd2, 32'sd3, 1'b0, 0);
    send_triangle(16'hAAAA, 16'h5555, 16'hF00F,
                  32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 1'b0, 0);
    send_triangle(16'h0004, 16'h0005, 16'h0006, 32'sd3, 32'sd2, 32'sd1, 1'b0, 0);
    send_triangle(16'h1234, 16'h5678, 16'h9ABC, -32'sd1, 32'sd0, 32'sd0, 1'b0, 0);
    send_triangle(16'h0007, 16'h0008, 16'h0009, 32'sd6, 32'sd0, 32'sd0, 1'b1, 0);

    // Directed: keys loaded in descending order, so the sort reverses them all.
    for (int k = 0; k < 5; k++) begin
      send_triangle(16'(k), 16'(k + 100), 16'(16'hFFFF - k),
                    32'sh0001_0000 * (5 - k), 32'sd0, -32'sd1, k == 4, 0);
    end

    // Directed: two identical maximum keys, first loaded first out.
    send_triangle(16'h00AA, 16'h00BB, 16'h00CC,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 0);
    send_triangle(16'h00DD, 16'h00EE, 16'h00FF,
                  32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b1, 0);

    directed_items = items_sent;

    // Random frames: mostly short, one that fills the store exactly and one
    // that overruns it so the tail, the item marked last included, is dropped.
    frame_no = 0;
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      if (frame_no == 2) frame_len = MAX_TRIANGLES_DEF;
      else if (frame_no == 5) frame_len = MAX_TRIANGLES_DEF + $urandom_range(1, 4);
      else frame_len = $urandom_range(1, 12);
      gappy      = (items_sent - directed_items < CALM_ITEMS) && $urandom_range(0, 1);
      frame_mode = depth_mode_t'($urandom_range(0, 2));
      for (int k = 0; k < frame_len; k++) begin
        mode = ($urandom_range(0, 3) == 0) ? depth_mode_t'($urandom_range(0, 2))
                                           : frame_mode;
        gap  = (gappy && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        send_triangle(16'($urandom), 16'($urandom), 16'($urandom),
                      pick_depth(mode), pick_depth(mode), pick_depth(mode),
                      k == frame_len - 1, gap);
      end
      frame_no++;
    end

    @(negedge clk);
    start      = 1'b0;
    in_last_in = 1'b0;

    // Drain: wait for the last frame to be emitted, then watch a little longer
    // for any stray strobe.
    do @(negedge clk); while (pending != 0 || busy);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Loaded %0d triangles in %0d frames, full and over-full stores included;",
             items_sent, frames_sent);
    $display("compared %0d sorted triangles against the prediction.", results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tds_pkg.sv
rtl/tds_ctrl.sv
rtl/tds_datapath.sv
rtl/triangle_depth_sorter.sv
test/tds_checker.sv
test/tb_top.sv
